/* hdl/gtg_pkg.sv */
package gtg_pkg;

	localparam int MAX_STEPS = 24;
	localparam int STEP_W    = 5;
	localparam int XY_W      = 32;
	localparam int Z_W       = 34;
	localparam int ERR_W     = 18;

	typedef logic [STEP_W-1:0] step_t;

	localparam logic CMD_POSE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	typedef enum logic [1:0] {
		REG_TARGET_X       = 2'd0,
		REG_TARGET_Y       = 2'd1,
		REG_ARRIVAL_RADIUS = 2'd2,
		REG_HEADING_GAIN   = 2'd3
	} reg_idx_t;

	localparam logic [15:0] TARGET_X_RST       = 16'd32768;
	localparam logic [15:0] TARGET_Y_RST       = 16'd16384;
	localparam logic [15:0] ARRIVAL_RADIUS_RST = 16'd2048;
	localparam logic [3:0]  HEADING_GAIN_RST   = 4'd6;

	localparam logic signed [Z_W-1:0]   HALF_PI_Q30  = 34'sd1686629713;
	localparam logic [29:0]             INV_GAIN_Q30 = 30'd652032874;
	localparam logic signed [ERR_W-1:0] PI_Q12       = 18'sd12868;
	localparam logic signed [ERR_W-1:0] TWO_PI_Q12   = 18'sd25736;

	typedef struct packed {
		logic [15:0] target_x;
		logic [15:0] target_y;
		logic [15:0] arrival_radius;
		logic [3:0]  heading_gain;
	} cfg_t;

	typedef struct packed {
		logic  pose_load;
		logic  pre_load;
		logic  iter_en;
		step_t iter_idx;
		logic  mul_en;
		logic  fin_en;
		logic  out_load;
	} dp_cmd_t;

	function automatic logic signed [Z_W-1:0] atan_q30(step_t idx);
		logic signed [Z_W-1:0] a;
		unique case (idx)
			5'd0:    a = 34'sd843314856;
			5'd1:    a = 34'sd497837829;
			5'd2:    a = 34'sd263043836;
			5'd3:    a = 34'sd133525158;
			5'd4:    a = 34'sd67021686;
			5'd5:    a = 34'sd33543515;
			5'd6:    a = 34'sd16775850;
			5'd7:    a = 34'sd8388437;
			5'd8:    a = 34'sd4194282;
			5'd9:    a = 34'sd2097149;
			5'd10:   a = 34'sd1048575;
			5'd11:   a = 34'sd524287;
			5'd12:   a = 34'sd262143;
			5'd13:   a = 34'sd131071;
			5'd14:   a = 34'sd65535;
			5'd15:   a = 34'sd32767;
			5'd16:   a = 34'sd16383;
			5'd17:   a = 34'sd8191;
			5'd18:   a = 34'sd4095;
			5'd19:   a = 34'sd2047;
			5'd20:   a = 34'sd1023;
			5'd21:   a = 34'sd511;
			5'd22:   a = 34'sd255;
			5'd23:   a = 34'sd127;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

/* hdl/gtg_regs.sv */
module gtg_regs (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            psel,
	input  logic            penable,
	input  logic            pwrite,
	input  logic [3:0]      paddr,
	input  logic [31:0]     pwdata,
	output logic [31:0]     prdata,
	output logic            pready,
	output gtg_pkg::cfg_t   cfg
);

	gtg_pkg::cfg_t    cfg_q;
	gtg_pkg::reg_idx_t idx;
	logic             wr_en;

	assign idx    = gtg_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_x       <= gtg_pkg::TARGET_X_RST;
			cfg_q.target_y       <= gtg_pkg::TARGET_Y_RST;
			cfg_q.arrival_radius <= gtg_pkg::ARRIVAL_RADIUS_RST;
			cfg_q.heading_gain   <= gtg_pkg::HEADING_GAIN_RST;
		end else if (wr_en) begin
			unique case (idx)
				gtg_pkg::REG_TARGET_X:       cfg_q.target_x       <= pwdata[15:0];
				gtg_pkg::REG_TARGET_Y:       cfg_q.target_y       <= pwdata[15:0];
				gtg_pkg::REG_ARRIVAL_RADIUS: cfg_q.arrival_radius <= pwdata[15:0];
				gtg_pkg::REG_HEADING_GAIN:   cfg_q.heading_gain   <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			gtg_pkg::REG_TARGET_X:       prdata = {16'b0, cfg_q.target_x};
			gtg_pkg::REG_TARGET_Y:       prdata = {16'b0, cfg_q.target_y};
			gtg_pkg::REG_ARRIVAL_RADIUS: prdata = {16'b0, cfg_q.arrival_radius};
			gtg_pkg::REG_HEADING_GAIN:   prdata = {28'b0, cfg_q.heading_gain};
			default:                     prdata = '0;
		endcase
	end

endmodule

/* hdl/gtg_ctrl.sv */
module gtg_ctrl #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               command,
	output logic               out_valid,
	input  logic               out_stall,
	output gtg_pkg::dp_cmd_t   cmd
);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_PRE  = 6'b000010,
		ST_ITER = 6'b000100,
		ST_MUL  = 6'b001000,
		ST_FIN  = 6'b010000,
		ST_OUT  = 6'b100000
	} state_t;

	localparam gtg_pkg::step_t LAST_STEP = gtg_pkg::step_t'(CORDIC_STEPS - 1);

	state_t         state_q;
	state_t         state_d;
	gtg_pkg::step_t step_q;
	logic           pose_seen_q;
	logic           out_valid_q;
	logic           accept;
	logic           out_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && (state_q == ST_IDLE);
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && command == gtg_pkg::CMD_TICK && pose_seen_q) begin
					state_d = ST_PRE;
				end
			end
			ST_PRE:  state_d = ST_ITER;
			ST_ITER: begin
				if (step_q == LAST_STEP) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL:  state_d = ST_FIN;
			ST_FIN:  state_d = ST_OUT;
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.pose_load = accept && command == gtg_pkg::CMD_POSE;
		cmd.pre_load  = (state_q == ST_PRE);
		cmd.iter_en   = (state_q == ST_ITER);
		cmd.iter_idx  = step_q;
		cmd.mul_en    = (state_q == ST_MUL);
		cmd.fin_en    = (state_q == ST_FIN);
		cmd.out_load  = (state_q == ST_OUT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			pose_seen_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_PRE) begin
				step_q <= '0;
			end else if (state_q == ST_ITER) begin
				step_q <= step_q + 1'b1;
			end
			if (cmd.pose_load) begin
				pose_seen_q <= 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || !out_stall))
		else $error("result word loaded over a waiting word");

	a_early_tick_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && command == gtg_pkg::CMD_TICK && !pose_seen_q) |=> state_q == ST_IDLE)
		else $error("tick before any pose started a computation");

	a_pose_marks_seen: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && command == gtg_pkg::CMD_POSE) |=> pose_seen_q)
		else $error("pose update did not set the seen flag");

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ITER) |-> (step_q <= LAST_STEP))
		else $error("iteration counter ran past the last step");

endmodule

/* hdl/gtg_dp.sv */
module gtg_dp (
	input  logic                clk,
	input  gtg_pkg::dp_cmd_t    cmd,
	input  gtg_pkg::cfg_t       cfg,
	input  logic [15:0]         pose_x,
	input  logic [15:0]         pose_y,
	input  logic signed [14:0]  pose_heading,
	output logic [16:0]         linear_speed,
	output logic signed [18:0]  angular_rate,
	output logic                arrived
);

	logic [15:0]                          last_x_q;
	logic [15:0]                          last_y_q;
	logic signed [14:0]                   last_heading_q;
	logic signed [gtg_pkg::XY_W-1:0]      x_q;
	logic signed [gtg_pkg::XY_W-1:0]      y_q;
	logic signed [gtg_pkg::Z_W-1:0]       z_q;
	logic [60:0]                          prod_q;
	logic [16:0]                          dist_q;
	logic                                 far_q;
	logic signed [gtg_pkg::ERR_W-1:0]     err_q;

	logic signed [16:0]                   dx;
	logic signed [16:0]                   dy;
	logic signed [gtg_pkg::XY_W-1:0]      dx_g;
	logic signed [gtg_pkg::XY_W-1:0]      dy_g;
	logic signed [gtg_pkg::XY_W-1:0]      xs;
	logic signed [gtg_pkg::XY_W-1:0]      ys;
	logic signed [gtg_pkg::Z_W-1:0]       atan_v;
	logic [30:0]                          x_pos;
	logic [61:0]                          rnd;
	logic [19:0]                          dist_full;
	logic [16:0]                          dist_sat;
	logic signed [gtg_pkg::Z_W-1:0]       z_rnd;
	logic signed [15:0]                   bearing;
	logic signed [gtg_pkg::ERR_W-1:0]     err_raw;
	logic signed [gtg_pkg::ERR_W-1:0]     err_wrap;
	logic signed [22:0]                   rate_full;

	always_comb begin
		dx   = $signed({1'b0, cfg.target_x}) - $signed({1'b0, last_x_q});
		dy   = $signed({1'b0, cfg.target_y}) - $signed({1'b0, last_y_q});
		dx_g = {{3{dx[16]}}, dx, 12'b0};
		dy_g = {{3{dy[16]}}, dy, 12'b0};

		xs     = x_q >>> cmd.iter_idx;
		ys     = y_q >>> cmd.iter_idx;
		atan_v = gtg_pkg::atan_q30(cmd.iter_idx);

		x_pos = x_q[gtg_pkg::XY_W-1] ? 31'd0 : x_q[30:0];

		rnd       = {1'b0, prod_q} + (62'd1 << 41);
		dist_full = rnd[61:42];
		dist_sat  = (|dist_full[19:17]) ? 17'h1FFFF : dist_full[16:0];

		z_rnd   = z_q + 34'sd131072;
		bearing = z_rnd[33:18];
		err_raw = {{2{bearing[15]}}, bearing} - {{3{last_heading_q[14]}}, last_heading_q};
		if (err_raw > gtg_pkg::PI_Q12) begin
			err_wrap = err_raw - gtg_pkg::TWO_PI_Q12;
		end else if (err_raw < -gtg_pkg::PI_Q12) begin
			err_wrap = err_raw + gtg_pkg::TWO_PI_Q12;
		end else begin
			err_wrap = err_raw;
		end

		rate_full = err_q * $signed({1'b0, cfg.heading_gain});
	end

	always_ff @(posedge clk) begin
		if (cmd.pose_load) begin
			last_x_q       <= pose_x;
			last_y_q       <= pose_y;
			last_heading_q <= pose_heading;
		end

		if (cmd.pre_load) begin
			if (!dx_g[gtg_pkg::XY_W-1]) begin
				x_q <= dx_g;
				y_q <= dy_g;
				z_q <= '0;
			end else if (!dy_g[gtg_pkg::XY_W-1]) begin
				x_q <= dy_g;
				y_q <= -dx_g;
				z_q <= gtg_pkg::HALF_PI_Q30;
			end else begin
				x_q <= -dy_g;
				y_q <= dx_g;
				z_q <= -gtg_pkg::HALF_PI_Q30;
			end
		end else if (cmd.iter_en) begin
			if (!y_q[gtg_pkg::XY_W-1]) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_v;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_v;
			end
		end

		if (cmd.mul_en) begin
			prod_q <= x_pos * gtg_pkg::INV_GAIN_Q30;
		end

		if (cmd.fin_en) begin
			dist_q <= dist_sat;
			far_q  <= dist_sat > {1'b0, cfg.arrival_radius};
			err_q  <= err_wrap;
		end

		if (cmd.out_load) begin
			linear_speed <= far_q ? dist_q : 17'd0;
			angular_rate <= far_q ? rate_full[18:0] : 19'sd0;
			arrived      <= !far_q;
		end
	end

endmodule

/* hdl/go_to_goal_steering.sv */
// Proportional go-to-goal steering controller.
// Input channel (in_valid, in_stall): one word per pose update or control tick.
// A word with command low stores pose_x, pose_y and pose_heading and yields
// no result. A word with command high is a control tick; before
// any pose has arrived it is dropped, otherwise it yields one result word.
// A tick passes through the pre-rotation, CORDIC_STEPS steps of the shared
// CORDIC rotator, which runs one step per cycle, the multiply and the final
// stage into the result register; in_stall is high until the block is idle.
// Output channel (out_valid, out_stall): linear_speed, angular_rate and
// arrived sit in an output register. While a result waits under out_stall
// the block returns to idle and takes the next word; a further tick then
// holds in its last cycle until the register is free.
// The APB port holds target_x, target_y, arrival_radius and heading_gain at
// byte addresses 0, 4, 8 and 12; write it only while the block is idle.
// Reset loads the register defaults, clears the pose-seen flag and empties
// the output register.
module go_to_goal_steering #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               command,
	input  logic [15:0]        pose_x,
	input  logic [15:0]        pose_y,
	input  logic signed [14:0] pose_heading,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [16:0]        linear_speed,
	output logic signed [18:0] angular_rate,
	output logic               arrived,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	gtg_pkg::cfg_t    cfg;
	gtg_pkg::dp_cmd_t cmd;

	gtg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	gtg_ctrl #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.command   (command),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	gtg_dp u_dp (
		.clk          (clk),
		.cmd          (cmd),
		.cfg          (cfg),
		.pose_x       (pose_x),
		.pose_y       (pose_y),
		.pose_heading (pose_heading),
		.linear_speed (linear_speed),
		.angular_rate (angular_rate),
		.arrived      (arrived)
	);

endmodule

/* tb/go_to_goal_steering_checker.sv */
module go_to_goal_steering_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic               command,
	input  logic [15:0]        pose_x,
	input  logic [15:0]        pose_y,
	input  logic signed [14:0] pose_heading,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [16:0]        linear_speed,
	input  logic signed [18:0] angular_rate,
	input  logic               arrived,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	input  logic               pready,
	output int                 fail_count,
	output int                 words_pending,
	output int                 words_checked,
	output int                 arrivals_seen
);

	localparam int     STEPS        = 16;
	localparam longint QUARTER_TURN = 64'sd1686629713;
	localparam longint INV_K_Q30    = 64'sd652032874;
	localparam longint HALF_TURN    = 64'sd12868;
	localparam longint FULL_TURN    = 64'sd25736;
	localparam longint SPEED_MAX    = 64'sd131071;

	typedef struct packed {
		logic [16:0]        speed;
		logic signed [18:0] rate;
		logic               arrived;
	} drive_cmd_t;

	logic [15:0]        goal_x;
	logic [15:0]        goal_y;
	logic [15:0]        radius;
	logic [3:0]         gain;
	logic [15:0]        held_x;
	logic [15:0]        held_y;
	logic signed [14:0] held_heading;
	logic               pose_seen;
	drive_cmd_t         expected_drive[$];
	int                 fails;
	int                 checked;
	int                 arrivals;

	function automatic longint arctan_step(int i);
		case (i)
			0:       return 64'sd843314856;
			1:       return 64'sd497837829;
			2:       return 64'sd263043836;
			3:       return 64'sd133525158;
			4:       return 64'sd67021686;
			5:       return 64'sd33543515;
			6:       return 64'sd16775850;
			7:       return 64'sd8388437;
			8:       return 64'sd4194282;
			9:       return 64'sd2097149;
			10:      return 64'sd1048575;
			11:      return 64'sd524287;
			12:      return 64'sd262143;
			13:      return 64'sd131071;
			14:      return 64'sd65535;
			15:      return 64'sd32767;
			default: return 64'sd0;
		endcase
	endfunction

	// Vector to the goal is scaled by 2^12, folded into the right half plane,
	// then rotated onto the x axis one CORDIC step at a time.
	function automatic drive_cmd_t steer_toward_goal(input logic [15:0] px,
			input logic [15:0] py, input logic signed [14:0] hd);
		longint     x, y, z, t, xs, ys, goal_dist, bearing, err, rate_full;
		int         i;
		drive_cmd_t r;
		x = (longint'(goal_x) - longint'(px)) * 64'sd4096;
		y = (longint'(goal_y) - longint'(py)) * 64'sd4096;
		z = 0;
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y;
				y = -t;
				z = QUARTER_TURN;
			end else begin
				x = -y;
				y = t;
				z = -QUARTER_TURN;
			end
		end
		for (i = 0; i < STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x += ys;
				y -= xs;
				z += arctan_step(i);
			end else begin
				x -= ys;
				y += xs;
				z -= arctan_step(i);
			end
		end
		if (x < 0)
			x = 0;
		goal_dist = (x * INV_K_Q30 + (longint'(1) <<< 41)) >>> 42;
		if (goal_dist > SPEED_MAX)
			goal_dist = SPEED_MAX;
		if (goal_dist > longint'(radius)) begin
			bearing = (z + (longint'(1) <<< 17)) >>> 18;
			err = bearing - longint'(hd);
			if (err > HALF_TURN)
				err -= FULL_TURN;
			else if (err < -HALF_TURN)
				err += FULL_TURN;
			rate_full = err * longint'(gain);
			r.speed = goal_dist[16:0];
			r.rate = rate_full[18:0];
			r.arrived = 1'b0;
		end else begin
			r.speed = '0;
			r.rate = '0;
			r.arrived = 1'b1;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		drive_cmd_t want;
		if (!arst_n) begin
			goal_x = gtg_pkg::TARGET_X_RST;
			goal_y = gtg_pkg::TARGET_Y_RST;
			radius = gtg_pkg::ARRIVAL_RADIUS_RST;
			gain = gtg_pkg::HEADING_GAIN_RST;
			held_x = '0;
			held_y = '0;
			held_heading = '0;
			pose_seen = 1'b0;
			expected_drive.delete();
			fails = 0;
			checked = 0;
			arrivals = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (gtg_pkg::reg_idx_t'(paddr[3:2]))
					gtg_pkg::REG_TARGET_X:       goal_x = pwdata[15:0];
					gtg_pkg::REG_TARGET_Y:       goal_y = pwdata[15:0];
					gtg_pkg::REG_ARRIVAL_RADIUS: radius = pwdata[15:0];
					gtg_pkg::REG_HEADING_GAIN:   gain = pwdata[3:0];
				endcase
			end
			if (in_valid && !in_stall) begin
				if (command == gtg_pkg::CMD_POSE) begin
					held_x = pose_x;
					held_y = pose_y;
					held_heading = pose_heading;
					pose_seen = 1'b1;
				end else if (pose_seen) begin
					expected_drive.push_back(steer_toward_goal(held_x, held_y, held_heading));
				end
			end
			if (out_valid && !out_stall) begin
				if (expected_drive.size() == 0) begin
					$error("result word arrived with none expected");
					fails++;
				end else begin
					want = expected_drive.pop_front();
					checked++;
					if (arrived)
						arrivals++;
					if (linear_speed !== want.speed) begin
						$error("linear_speed: expected %0d, got %0d", want.speed, linear_speed);
						fails++;
					end
					if (angular_rate !== want.rate) begin
						$error("angular_rate: expected %0d, got %0d", want.rate, angular_rate);
						fails++;
					end
					if (arrived !== want.arrived) begin
						$error("arrived: expected %0d, got %0d", want.arrived, arrived);
						fails++;
					end
				end
			end
		end
		fail_count <= fails;
		words_pending <= expected_drive.size();
		words_checked <= checked;
		arrivals_seen <= arrivals;
	end

endmodule

/* tb/go_to_goal_steering_tb.sv */
module go_to_goal_steering_tb;

	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_CYCLES = 40;
	localparam int PHASE_WORDS = 250;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               command = gtg_pkg::CMD_POSE;
	logic [15:0]        pose_x = '0;
	logic [15:0]        pose_y = '0;
	logic signed [14:0] pose_heading = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [16:0]        linear_speed;
	logic signed [18:0] angular_rate;
	logic               arrived;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [3:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;

	int fail_count;
	int words_pending;
	int words_checked;
	int arrivals_seen;

	bit          quiet = 1'b0;
	int          stall_left = 0;
	int          cycle_count = 0;
	int          poses_sent = 0;
	int          ticks_sent = 0;
	logic [15:0] cur_tx = gtg_pkg::TARGET_X_RST;
	logic [15:0] cur_ty = gtg_pkg::TARGET_Y_RST;
	logic [15:0] cur_radius = gtg_pkg::ARRIVAL_RADIUS_RST;

	go_to_goal_steering i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.pose_x       (pose_x),
		.pose_y       (pose_y),
		.pose_heading (pose_heading),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.linear_speed (linear_speed),
		.angular_rate (angular_rate),
		.arrived      (arrived),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	go_to_goal_steering_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.command       (command),
		.pose_x        (pose_x),
		.pose_y        (pose_y),
		.pose_heading  (pose_heading),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.linear_speed  (linear_speed),
		.angular_rate  (angular_rate),
		.arrived       (arrived),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.pready        (pready),
		.fail_count    (fail_count),
		.words_pending (words_pending),
		.words_checked (words_checked),
		.arrivals_seen (arrivals_seen)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (!quiet && $urandom_range(0, 4) == 0) begin
			stall_left = $urandom_range(0, 2);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic send_word(input logic cmd, input logic [15:0] px, input logic [15:0] py,
			input logic signed [14:0] hd);
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 3);
			repeat (gap) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
		end
		@(negedge clk);
		in_valid <= 1'b1;
		command <= cmd;
		pose_x <= px;
		pose_y <= py;
		pose_heading <= hd;
		do
			@(posedge clk);
		while (in_stall);
		if (cmd == gtg_pkg::CMD_POSE)
			poses_sent++;
		else
			ticks_sent++;
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (words_pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input gtg_pkg::reg_idx_t idx, input logic [15:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {16'($urandom), value};
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_goal(input logic [15:0] tx, input logic [15:0] ty,
			input logic [15:0] rad, input logic [3:0] g);
		settle();
		apb_write(gtg_pkg::REG_TARGET_X, tx);
		apb_write(gtg_pkg::REG_TARGET_Y, ty);
		apb_write(gtg_pkg::REG_ARRIVAL_RADIUS, rad);
		apb_write(gtg_pkg::REG_HEADING_GAIN, {12'($urandom), g});
		cur_tx = tx;
		cur_ty = ty;
		cur_radius = rad;
	endtask

	function automatic logic [15:0] near_goal(input logic [15:0] centre, input int span);
		int v;
		v = int'(centre) + int'($urandom_range(0, 2 * span)) - span;
		if (v < 0)
			v = 0;
		if (v > 65535)
			v = 65535;
		return v[15:0];
	endfunction

	// Poses near the goal are favored so that the arrival branch is hit often.
	task automatic send_random_words(input int count);
		logic [15:0]        px, py;
		logic signed [14:0] hd;
		logic               cmd;
		int                 span;
		repeat (count) begin
			px = 16'($urandom);
			py = 16'($urandom);
			if ($urandom_range(0, 9) < 3) begin
				span = 2 * int'(cur_radius) + 64;
				px = near_goal(cur_tx, span);
				py = near_goal(cur_ty, span);
			end
			if ($urandom_range(0, 9) == 0)
				hd = $urandom_range(0, 1) ? 15'sd12868 : -15'sd12868;
			else
				hd = 15'(int'($urandom_range(0, 25736)) - 12868);
			cmd = ($urandom_range(0, 9) < 4) ? gtg_pkg::CMD_POSE : gtg_pkg::CMD_TICK;
			send_word(cmd, px, py, hd);
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_word(gtg_pkg::CMD_TICK, 16'd0, 16'd0, 15'sd0);
		send_word(gtg_pkg::CMD_TICK, 16'hFFFF, 16'hFFFF, -15'sd1);
		send_word(gtg_pkg::CMD_POSE, 16'd0, 16'd0, 15'sd0);
		send_word(gtg_pkg::CMD_TICK, 16'd0, 16'd0, 15'sd0);
		send_word(gtg_pkg::CMD_TICK, 16'd0, 16'd0, 15'sd0);
		send_word(gtg_pkg::CMD_POSE, 16'd32768, 16'd16384, 15'sd12868);
		send_word(gtg_pkg::CMD_TICK, 16'd0, 16'd0, 15'sd0);
		send_word(gtg_pkg::CMD_POSE, 16'hFFFF, 16'hFFFF, -15'sd12868);
		send_word(gtg_pkg::CMD_TICK, 16'd0, 16'd0, 15'sd0);
		send_word(gtg_pkg::CMD_POSE, 16'hFFFF, 16'd0, 15'sd12868);
		send_word(gtg_pkg::CMD_TICK, 16'd0, 16'd0, 15'sd0);
		send_word(gtg_pkg::CMD_POSE, 16'hFFFF, 16'd16384, -15'sd12868);
		send_word(gtg_pkg::CMD_TICK, 16'd0, 16'd0, 15'sd0);
		send_word(gtg_pkg::CMD_POSE, 16'd32768, 16'hFFFF, 15'sd12868);
		send_word(gtg_pkg::CMD_TICK, 16'd0, 16'd0, 15'sd0);
		send_word(gtg_pkg::CMD_POSE, 16'd0, 16'hFFFF, -15'sd1);
		send_word(gtg_pkg::CMD_TICK, 16'd0, 16'd0, 15'sd0);
		send_word(gtg_pkg::CMD_POSE, 16'd34816, 16'd16384, 15'sd0);
		send_word(gtg_pkg::CMD_TICK, 16'd0, 16'd0, 15'sd0);
		send_word(gtg_pkg::CMD_POSE, 16'd34817, 16'd16384, 15'sd0);
		send_word(gtg_pkg::CMD_TICK, 16'd0, 16'd0, 15'sd0);
		send_random_words(PHASE_WORDS - 20);

		set_goal(16'd0, 16'd0, 16'd0, 4'd0);
		send_word(gtg_pkg::CMD_POSE, 16'd0, 16'd0, 15'sd0);
		send_word(gtg_pkg::CMD_TICK, 16'd0, 16'd0, 15'sd0);
		send_word(gtg_pkg::CMD_POSE, 16'hFFFF, 16'hFFFF, -15'sd12868);
		send_word(gtg_pkg::CMD_TICK, 16'd0, 16'd0, 15'sd0);
		send_random_words(PHASE_WORDS);

		set_goal(16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd15);
		send_word(gtg_pkg::CMD_POSE, 16'd0, 16'd0, 15'sd12868);
		send_word(gtg_pkg::CMD_TICK, 16'd0, 16'd0, 15'sd0);
		send_random_words(PHASE_WORDS);

		set_goal(16'hFFFF, 16'd0, 16'd0, 4'd15);
		send_word(gtg_pkg::CMD_POSE, 16'd0, 16'hFFFF, -15'sd12868);
		send_word(gtg_pkg::CMD_TICK, 16'd0, 16'd0, 15'sd0);
		send_random_words(PHASE_WORDS);

		set_goal(16'($urandom), 16'($urandom), 16'($urandom_range(0, 4095)),
			4'($urandom));
		send_random_words(PHASE_WORDS);

		set_goal(16'($urandom), 16'($urandom), 16'($urandom_range(0, 4095)),
			4'($urandom));
		quiet = 1'b1;
		send_random_words(PHASE_WORDS);

		settle();
		$display("Covered %0d pose updates and %0d control ticks over six goal settings.",
			poses_sent, ticks_sent);
		$display("%0d result words compared, %0d of them reporting arrival.",
			words_checked, arrivals_seen);
		if (fail_count == 0 && words_pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
